>>> rtl/qewe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qewe_pkg: shared types and constants for the quadrature wheel event block
// Request layouts, configuration register map, quadrature step table and
// the record that passes from the front part to the event serialiser.
// ----------------------------------------------------------------------------
package qewe_pkg;

  // Block dimensions
  localparam int unsigned NumEnc    = 5;
  localparam int unsigned NumSw     = 4;
  localparam int unsigned CcW       = 7;
  localparam int unsigned CfgDataW  = NumEnc * CcW;
  localparam int unsigned CfgIdxW   = 3;

  // Fixed message encodings
  localparam logic [7:0]     CcStatus = 8'hB0;
  localparam logic [CcW-1:0] CwValue  = 7'd65;
  localparam logic [CcW-1:0] CcwValue = 7'd63;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMidiChannel  = 3'd0,
    CfgDetentSteps  = 3'd1,
    CfgDebounce     = 3'd2,
    CfgNormalCc     = 3'd3,
    CfgShiftedCc    = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [3:0]                MidiChannelRst = 4'd0;
  localparam logic [2:0]                DetentRst      = 3'd4;
  localparam logic [3:0]                DebounceRst    = 4'd5;
  localparam logic [NumEnc*CcW-1:0]     NormalCcRst    = 35'd6488918288;
  localparam logic [(NumEnc-1)*CcW-1:0] ShiftedCcRst   = 28'd52808339;

  // 4x quadrature step, index {prev A, prev B, cur A, cur B}, two's complement
  localparam logic [1:0] StepTable [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

  typedef struct packed {
    logic [3:0]                midi_channel;
    logic [2:0]                detent_steps;
    logic [3:0]                debounce_ticks;
    logic [NumEnc*CcW-1:0]     normal_controllers;
    logic [(NumEnc-1)*CcW-1:0] shifted_controllers;
  } cfg_t;

  typedef struct packed {
    logic [NumEnc-1:0] phase_a_levels;
    logic [NumEnc-1:0] phase_b_levels;
    logic [NumSw-1:0]  switch_pressed;
    logic              link_ready;
  } in_t;

  typedef struct packed {
    logic [7:0]     status_byte;
    logic [CcW-1:0] controller;
    logic [CcW-1:0] wheel_value;
    logic           last_of_tick;
  } out_t;

  // One tick's worth of pending events
  typedef struct packed {
    logic [NumEnc-1:0] evt;
    logic [NumEnc-1:0] cw;
    logic [NumSw-1:0]  held;
  } rec_t;

endpackage

>>> rtl/qewe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qewe_front: switch debounce and quadrature decode
// Takes one sample tick per cycle while take_i is high, updates the debounce
// and step state and queues a record of the encoders that reached a detent.
// ----------------------------------------------------------------------------
module qewe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qewe_pkg::cfg_t   cfg_i,
  input  logic             take_i,
  input  qewe_pkg::in_t    in_i,
  output logic             rec_we_o,
  output qewe_pkg::rec_t   rec_o
);

  logic [qewe_pkg::NumEnc-1:0][1:0] prev_q, prev_d;
  logic [qewe_pkg::NumEnc-1:0][3:0] acc_q, acc_d;
  logic [qewe_pkg::NumSw-1:0][3:0]  cnt_q, cnt_d;
  logic [qewe_pkg::NumSw-1:0]       held_q, held_d;
  logic [qewe_pkg::NumEnc-1:0]      evt, cw;

  // Debounce: toggle after enough consecutive differing ticks
  always_comb begin
    logic [3:0] inc;
    held_d = held_q;
    cnt_d  = cnt_q;
    for (int j = 0; j < qewe_pkg::NumSw; j++) begin
      inc = cnt_q[j] + 4'd1;
      if (in_i.switch_pressed[j] != held_q[j]) begin
        if (inc >= cfg_i.debounce_ticks) begin
          held_d[j] = ~held_q[j];
          cnt_d[j]  = 4'd0;
        end else begin
          cnt_d[j] = inc;
        end
      end else begin
        cnt_d[j] = 4'd0;
      end
    end
  end

  // Quadrature decode and detent accumulation per encoder
  always_comb begin
    logic [1:0]        cur;
    logic signed [1:0] step;
    logic signed [4:0] sum;
    logic signed [4:0] det;
    prev_d = prev_q;
    acc_d  = acc_q;
    evt    = '0;
    cw     = '0;
    det    = signed'({2'b00, cfg_i.detent_steps});
    for (int i = 0; i < qewe_pkg::NumEnc; i++) begin
      cur       = {in_i.phase_a_levels[i], in_i.phase_b_levels[i]};
      step      = signed'(qewe_pkg::StepTable[{prev_q[i], cur}]);
      sum       = 5'(signed'(acc_q[i])) + 5'(step);
      prev_d[i] = cur;
      if (step != 2'sd0) begin
        if (sum >= det || sum <= -det) begin
          evt[i]   = 1'b1;
          cw[i]    = (sum > 5'sd0);
          acc_d[i] = 4'd0;
        end else begin
          acc_d[i] = sum[3:0];
        end
      end
    end
  end

  assign rec_o.evt  = evt;
  assign rec_o.cw   = cw;
  assign rec_o.held = held_d;
  // Nothing is queued while the link is down; state still moves on
  assign rec_we_o   = take_i && in_i.link_ready && (|evt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '1;
      acc_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
    end else if (take_i) begin
      prev_q <= prev_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

endmodule

>>> rtl/qewe_rec_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qewe_rec_fifo: two-entry record queue
// Decouples the per-tick front part from the event serialiser.
// ----------------------------------------------------------------------------
module qewe_rec_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  qewe_pkg::rec_t wdata_i,
  output logic           full_o,
  input  logic           re_i,
  output logic           valid_o,
  output qewe_pkg::rec_t rdata_o
);

  qewe_pkg::rec_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (we_i) begin
        wptr_q <= ~wptr_q;
      end
      if (re_i) begin
        rptr_q <= ~rptr_q;
      end
      if (we_i && !re_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (re_i && !we_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> rtl/qewe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qewe_back: event serialiser
// Walks the encoders of the head record in index order, one event a cycle
// while the result register is empty or popped, into the result register.
// ----------------------------------------------------------------------------
module qewe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qewe_pkg::cfg_t cfg_i,
  input  logic           rec_valid_i,
  input  qewe_pkg::rec_t rec_i,
  output logic           rec_re_o,
  input  logic           pop_i,
  output logic           empty_o,
  output qewe_pkg::out_t out_o
);

  logic [qewe_pkg::NumEnc-1:0] done_q, done_d;
  logic [qewe_pkg::NumEnc-1:0] pend, sel, rest;
  logic [qewe_pkg::NumEnc-1:0] held_by_enc;
  logic [qewe_pkg::CcW-1:0]    cc;
  logic                        adv, out_vld_q;
  qewe_pkg::out_t              out_q, out_d;

  // Remaining events of the head record, lowest encoder first
  assign pend = rec_valid_i ? (rec_i.evt & ~done_q) : '0;
  assign sel  = pend & (~pend + 1'b1);
  assign rest = pend & ~sel;
  assign adv  = (|pend) && (!out_vld_q || pop_i);

  // Encoder i uses switch i-1; encoder 0 has none
  always_comb begin
    held_by_enc = '0;
    for (int i = 1; i < qewe_pkg::NumEnc; i++) begin
      if (i - 1 < qewe_pkg::NumSw) begin
        held_by_enc[i] = rec_i.held[i-1];
      end
    end
  end

  // Controller number of the selected encoder
  always_comb begin
    cc = '0;
    for (int i = 0; i < qewe_pkg::NumEnc; i++) begin
      if (sel[i]) begin
        cc = cfg_i.normal_controllers[i*qewe_pkg::CcW +: qewe_pkg::CcW];
      end
    end
    // Shifted numbers exist from encoder 1 upwards
    for (int i = 1; i < qewe_pkg::NumEnc; i++) begin
      if (sel[i] && held_by_enc[i]) begin
        cc = cfg_i.shifted_controllers[(i-1)*qewe_pkg::CcW +: qewe_pkg::CcW];
      end
    end
  end

  always_comb begin
    out_d.status_byte  = qewe_pkg::CcStatus | {4'd0, cfg_i.midi_channel};
    out_d.controller   = cc;
    out_d.wheel_value  = (|(sel & rec_i.cw)) ? qewe_pkg::CwValue : qewe_pkg::CcwValue;
    out_d.last_of_tick = (rest == '0);
  end

  // Record retires with its last event
  assign rec_re_o = adv && (rest == '0);
  assign done_d   = rec_re_o ? '0 : (done_q | sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        done_q <= done_d;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;

endmodule

>>> rtl/quadrature_encoder_wheel_events_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_wheel_events_core: rotary encoder to control-change events
// Debounces the shift switches, decodes five quadrature encoders and emits
// one control-change event per detent while the link is ready, in encoder order.
// ----------------------------------------------------------------------------
// Usage
//   Input queue: present one sample tick on in_i with push_i; it is taken
//   at an edge where push_i is high and full_o is low. A tick can be taken
//   every cycle while the record queue has room.
//   Result queue: while empty_o is low the oldest event sits on out_o; pop_i
//   takes it. last_of_tick marks the final event of a tick.
//   A tick's events pass through the record queue and then the result
//   register. Events leave the result register at one a cycle while pop_i
//   is high; a tick yields at most five events, and this serialiser sets
//   the sustained rate.
//   A two-entry record queue sits between decoder and serialiser. When the
//   receiver stalls, the result register holds, the queue fills and full_o
//   rises; ticks with no events to send are still taken meanwhile only if
//   the queue has room.
//   Reset: phases idle high, step counts, debounce counts and switch states
//   clear, configuration returns to its defaults; both queues empty.
//   Configuration: cfg_we_i writes cfg_wdata_i to the register at cfg_idx_i
//   with no wait; unknown indexes are ignored. Write only while idle.
// ----------------------------------------------------------------------------
module quadrature_encoder_wheel_events_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  qewe_pkg::in_t                      in_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output qewe_pkg::out_t                     out_o,
  input  logic                               cfg_we_i,
  input  logic [qewe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [qewe_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  qewe_pkg::cfg_t cfg_q;
  qewe_pkg::rec_t rec_w, rec_r;
  logic           take, rec_we, rec_re, rec_vld, rec_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.midi_channel        <= qewe_pkg::MidiChannelRst;
      cfg_q.detent_steps        <= qewe_pkg::DetentRst;
      cfg_q.debounce_ticks      <= qewe_pkg::DebounceRst;
      cfg_q.normal_controllers  <= qewe_pkg::NormalCcRst;
      cfg_q.shifted_controllers <= qewe_pkg::ShiftedCcRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qewe_pkg::CfgMidiChannel: cfg_q.midi_channel   <= cfg_wdata_i[3:0];
        qewe_pkg::CfgDetentSteps: cfg_q.detent_steps   <= cfg_wdata_i[2:0];
        qewe_pkg::CfgDebounce:    cfg_q.debounce_ticks <= cfg_wdata_i[3:0];
        qewe_pkg::CfgNormalCc:    cfg_q.normal_controllers <= cfg_wdata_i;
        qewe_pkg::CfgShiftedCc:
          cfg_q.shifted_controllers <=
            cfg_wdata_i[(qewe_pkg::NumEnc-1)*qewe_pkg::CcW-1:0];
        default: ;
      endcase
    end
  end

  assign full_o = rec_full;
  assign take   = push_i && !rec_full;

  qewe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .take_i   (take),
    .in_i     (in_i),
    .rec_we_o (rec_we),
    .rec_o    (rec_w)
  );

  qewe_rec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rec_we),
    .wdata_i (rec_w),
    .full_o  (rec_full),
    .re_i    (rec_re),
    .valid_o (rec_vld),
    .rdata_o (rec_r)
  );

  qewe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (rec_vld),
    .rec_i       (rec_r),
    .rec_re_o    (rec_re),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_o)
  );

endmodule

>>> rtl/qewe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qewe_checker: port-level checks for the wheel event block
// Watches the result queue of the top level; attached by bind.
// ----------------------------------------------------------------------------
module qewe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty_o,
  input logic           pop_i,
  input qewe_pkg::out_t out_o
);

  // A waiting event holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_o)))
    else $error("result changed while stalled");

  // Status byte is always a control change
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_o.status_byte[7:4] == qewe_pkg::CcStatus[7:4]))
    else $error("bad status byte");

  // Only the two wheel values exist
  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_o.wheel_value == qewe_pkg::CwValue ||
                  out_o.wheel_value == qewe_pkg::CcwValue))
    else $error("bad wheel value");

  // Events of one tick follow back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !out_o.last_of_tick) |=> !empty_o)
    else $error("gap inside a tick's events");

endmodule

bind quadrature_encoder_wheel_events_core qewe_checker u_qewe_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quadrature_encoder_wheel_events_core
// Drives sample ticks through the request queue, predicts the control-change
// events from a local model of the debounce, quadrature decode and detent
// logic, and compares every popped event field by field. Covers directed
// turns, link-down ticks, invalid transitions, shift switches, several
// register settings including the extremes, receiver back-pressure and
// random traffic with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import qewe_pkg::*;

  localparam int ClkHalf     = 6;
  localparam int ResetCycles = 5;
  localparam int DrainCycles = 10;
  localparam int StallCycles = 400;
  localparam int IdleLimit   = 2000;
  localparam int NumCfgRegs  = 5;

  // Step per {previous A, previous B, current A, current B}
  localparam int QuadStep [16] = '{
    0, -1, 1, 0,
    1, 0, 0, -1,
    -1, 0, 0, 1,
    0, 1, -1, 0
  };
  // Wheel positions in clockwise order, {A, B}
  localparam logic [1:0] WheelGray [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push_i;
  logic                 full_o;
  in_t                  in_i;
  logic                 empty_o;
  logic                 pop_i;
  out_t                 out_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;

  // Local copy of the block's state and registers
  cfg_t              shadow_cfg;
  logic [1:0]        model_phase [NumEnc];
  int                wheel_sum [NumEnc];
  logic [3:0]        bounce_cnt [NumSw];
  logic [NumSw-1:0]  held_sw;

  out_t pending_events [$];
  int   mismatch_count;

  // Stimulus state
  int                wheel_pos [NumEnc];
  logic [NumEnc-1:0] spin_cw;
  logic [NumSw-1:0]  sw_target;
  int                push_idle_pct;
  int                pop_idle_pct;
  bit                stall_req;
  int                idle_cycles;

  quadrature_encoder_wheel_events_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Expected events of one tick; state advances even when the link is down
  function automatic void predict_wheel_events(input in_t t);
    out_t       evs [NumEnc];
    logic [1:0] cur;
    logic [6:0] cc;
    int         n;
    int         step;
    int         acc;
    int         det;
    n = 0;
    det = int'(shadow_cfg.detent_steps);
    for (int j = 0; j < NumSw; j++) begin
      if (t.switch_pressed[j] != held_sw[j]) begin
        bounce_cnt[j] = bounce_cnt[j] + 4'd1;
        if (bounce_cnt[j] >= shadow_cfg.debounce_ticks) begin
          held_sw[j] = ~held_sw[j];
          bounce_cnt[j] = '0;
        end
      end else begin
        bounce_cnt[j] = '0;
      end
    end
    for (int i = 0; i < NumEnc; i++) begin
      cur = {t.phase_a_levels[i], t.phase_b_levels[i]};
      step = QuadStep[{model_phase[i], cur}];
      model_phase[i] = cur;
      if (step != 0) begin
        acc = wheel_sum[i] + step;
        if (acc >= det || acc <= -det) begin
          wheel_sum[i] = 0;
          cc = shadow_cfg.normal_controllers[CcW*i +: CcW];
          if (i >= 1) begin
            if (i - 1 < NumSw && held_sw[i-1])
              cc = shadow_cfg.shifted_controllers[CcW*(i-1) +: CcW];
          end
          if (t.link_ready) begin
            evs[n] = '{status_byte:  CcStatus | {4'h0, shadow_cfg.midi_channel},
                       controller:   cc,
                       wheel_value:  (acc > 0) ? CwValue : CcwValue,
                       last_of_tick: 1'b0};
            n++;
          end
        end else begin
          wheel_sum[i] = acc;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) evs[k].last_of_tick = 1'b1;
      pending_events.push_back(evs[k]);
    end
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_events
    out_t exp_ev;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual controller %0d value %0d",
                 $time, out_o.controller, out_o.wheel_value);
        mismatch_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        check_field("status_byte", exp_ev.status_byte, out_o.status_byte);
        check_field("controller", exp_ev.controller, out_o.controller);
        check_field("wheel_value", exp_ev.wheel_value, out_o.wheel_value);
        check_field("last_of_tick", exp_ev.last_of_tick, out_o.last_of_tick);
      end
    end
  end

  // Receiver: random pops, with a long hold-off on request
  initial begin : receiver
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        pop_i <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
      end else begin
        pop_i <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted request or event
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one tick; push stays high afterwards unless a gap follows
  task automatic send_tick(input in_t t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < push_idle_pct) gap++;
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_i   <= t;
    do @(posedge clk_i); while (full_o);
    predict_wheel_events(t);
  endtask

  // Move each wheel one position forward, back, or two (invalid jump)
  task automatic step_wheels(input logic [NumEnc-1:0] fwd, input logic [NumEnc-1:0] rev,
                             input logic [NumEnc-1:0] jump, input logic [NumSw-1:0] sw,
                             input logic rdy);
    in_t        t;
    logic [1:0] ab;
    for (int i = 0; i < NumEnc; i++) begin
      if (fwd[i]) wheel_pos[i] = (wheel_pos[i] + 1) % 4;
      else if (rev[i]) wheel_pos[i] = (wheel_pos[i] + 3) % 4;
      else if (jump[i]) wheel_pos[i] = (wheel_pos[i] + 2) % 4;
      ab = WheelGray[wheel_pos[i]];
      t.phase_a_levels[i] = ab[1];
      t.phase_b_levels[i] = ab[0];
    end
    t.switch_pressed = sw;
    t.link_ready = rdy;
    send_tick(t);
  endtask

  // Mostly steady turning with reversals, jumps, switch bounce and link drops
  task automatic random_tick();
    logic [NumEnc-1:0] fwd;
    logic [NumEnc-1:0] rev;
    logic [NumEnc-1:0] jmp;
    logic [NumSw-1:0]  sw;
    logic [31:0]       rnd;
    int                r;
    fwd = '0;
    rev = '0;
    jmp = '0;
    rnd = $urandom;
    if ($urandom_range(19) == 0) spin_cw = rnd[NumEnc-1:0];
    if ($urandom_range(24) == 0) sw_target = rnd[NumEnc+NumSw-1:NumEnc];
    for (int i = 0; i < NumEnc; i++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        if (spin_cw[i]) fwd[i] = 1'b1;
        else rev[i] = 1'b1;
      end else if (r < 72) begin
        if (spin_cw[i]) rev[i] = 1'b1;
        else fwd[i] = 1'b1;
      end else if (r < 80) begin
        jmp[i] = 1'b1;
      end
    end
    sw = sw_target;
    for (int j = 0; j < NumSw; j++)
      if ($urandom_range(9) == 0) sw[j] = ~sw[j];
    step_wheels(fwd, rev, jmp, sw, $urandom_range(9) != 0);
  endtask

  // Stop offering and wait until every expected event has come out
  task automatic settle();
    push_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgMidiChannel: shadow_cfg.midi_channel        = val[3:0];
      CfgDetentSteps: shadow_cfg.detent_steps        = val[2:0];
      CfgDebounce:    shadow_cfg.debounce_ticks      = val[3:0];
      CfgNormalCc:    shadow_cfg.normal_controllers  = val[NumEnc*CcW-1:0];
      CfgShiftedCc:   shadow_cfg.shifted_controllers = val[(NumEnc-1)*CcW-1:0];
      default: ;
    endcase
  endtask

  // Full register set, preceded by a write to an unmapped index
  task automatic apply_config(input cfg_t c);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'({$urandom, $urandom});
    write_reg(CfgIdxW'(NumCfgRegs + $urandom_range(2)), junk);
    write_reg(CfgMidiChannel, CfgDataW'(c.midi_channel));
    write_reg(CfgDetentSteps, CfgDataW'(c.detent_steps));
    write_reg(CfgDebounce, CfgDataW'(c.debounce_ticks));
    write_reg(CfgNormalCc, CfgDataW'(c.normal_controllers));
    write_reg(CfgShiftedCc, CfgDataW'(c.shifted_controllers));
    cfg_we_i <= 1'b0;
  endtask

  // Defaults: full turns, link down, invalid jumps, shift switches
  task automatic test_directed_turns();
    for (int k = 0; k < 4; k++) step_wheels('1, '0, '0, '0, 1'b1);
    for (int k = 0; k < 4; k++) step_wheels('0, '1, '0, '0, 1'b1);
    step_wheels('0, '0, '1, '0, 1'b1);
    for (int k = 0; k < 4; k++) step_wheels('1, '0, '0, '0, 1'b0);
    for (int k = 0; k < 5; k++) step_wheels('0, '0, '0, '1, 1'b1);
    for (int k = 0; k < 4; k++) step_wheels('1, '0, '0, '1, 1'b1);
    settle();
  endtask

  // Receiver holds off while the sender keeps turning every wheel
  task automatic test_backpressure();
    push_idle_pct = 0;
    stall_req = 1'b1;
    for (int k = 0; k < 40; k++) step_wheels('1, '0, '0, sw_target, 1'b1);
    push_idle_pct = 18;
    settle();
  endtask

  task automatic test_random_traffic(input int count);
    for (int k = 0; k < count; k++) random_tick();
    settle();
  endtask

  // Extremes of every register, the zero cases, then random settings
  task automatic test_config_sweep();
    cfg_t c;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: c = '{midi_channel: 4'hF, detent_steps: 3'd1, debounce_ticks: 4'd1,
                 normal_controllers: '1, shifted_controllers: '0};
        1: c = '{midi_channel: 4'h0, detent_steps: 3'd7, debounce_ticks: 4'd15,
                 normal_controllers: '0, shifted_controllers: '1};
        2: c = '{midi_channel: 4'(($urandom)), detent_steps: 3'd0, debounce_ticks: 4'd0,
                 normal_controllers: 35'({$urandom, $urandom}),
                 shifted_controllers: 28'($urandom)};
        default: c = '{midi_channel: 4'($urandom),
                       detent_steps: 3'($urandom_range(7, 1)),
                       debounce_ticks: 4'($urandom_range(15, 1)),
                       normal_controllers: 35'({$urandom, $urandom}),
                       shifted_controllers: 28'($urandom)};
      endcase
      apply_config(c);
      test_random_traffic(60);
    end
  endtask

  // Long stretch with both sides running flat out
  task automatic test_no_idle();
    push_idle_pct = 0;
    pop_idle_pct = 0;
    test_random_traffic(70);
    push_idle_pct = 18;
    pop_idle_pct = 18;
  endtask

  initial begin : main
    shadow_cfg = '{midi_channel: MidiChannelRst, detent_steps: DetentRst,
                   debounce_ticks: DebounceRst, normal_controllers: NormalCcRst,
                   shifted_controllers: ShiftedCcRst};
    for (int i = 0; i < NumEnc; i++) begin
      model_phase[i] = 2'b11;
      wheel_sum[i] = 0;
      wheel_pos[i] = 0;
    end
    for (int j = 0; j < NumSw; j++) bounce_cnt[j] = '0;
    held_sw = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    spin_cw = '1;
    sw_target = '0;
    push_idle_pct = 18;
    pop_idle_pct = 18;
    stall_req = 1'b0;
    rst_ni      <= 1'b0;
    push_i      <= 1'b0;
    in_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_turns();
    test_backpressure();
    test_random_traffic(40);
    test_config_sweep();
    test_no_idle();
    settle();

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qewe_pkg.sv
rtl/qewe_front.sv
rtl/qewe_rec_fifo.sv
rtl/qewe_back.sv
rtl/quadrature_encoder_wheel_events_core.sv
rtl/qewe_checker.sv
dv/testbench.sv
